### rtl/core/kfg_pkg.sv
// Shared constants for the Kuwahara filter core: register map and stream field layout.
`default_nettype none
package kfg_pkg;

    // Configuration register map (index = paddr[3:2]).
    localparam int          CFG_ADDR_W        = 4;
    localparam logic [1:0]  REG_QUADRANT_SIDE = 2'd0;
    localparam logic [1:0]  REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0]  REG_IMAGE_HEIGHT  = 2'd2;

    localparam int          QS_W   = 5;
    localparam int          DIM_W  = 11;

    // Stream fields.
    localparam int          PIX_W      = 8;
    localparam int          POS_W      = 10;
    localparam int          IN_TDATA_W = 8;
    localparam int          OUT_TDATA_W = 32;
    localparam int          OUT_PAD_W  = OUT_TDATA_W - PIX_W - 2 * POS_W;

endpackage
`default_nettype wire

### rtl/core/kfg_div.sv
// Restoring divider, one quotient bit per cycle, for the quadrant mean.
`default_nettype none
module kfg_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic                       done
);

    localparam int RW = DIVISOR_W + 1;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [RW-1:0]         rem_reg;
    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [RW-1:0]         shifted;
    logic                  take;

    // Shift the next dividend bit into the partial remainder and try a subtraction.
    assign shifted = {rem_reg[DIVISOR_W-1:0], dq_reg[DIVIDEND_W-1]};
    assign take    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= shifted - {1'b0, dvs_reg};
                dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

### rtl/core/kuwahara_filter_gray_core.sv
// Top level of the streaming Kuwahara filter for 8-bit gray pixels.
//
// Pixels enter on the s_ stream in raster order, one per transfer, and the block
// counts rows and columns itself. Results leave on the m_ stream with the pixel
// value, its row and its column; tlast marks the final result caused by one input.
// A pixel within q of a frame edge is returned unchanged in the same run as its
// input. An interior pixel is returned filtered once the bottom-right corner of its
// window arrives, ahead of any border result of that input, so results may leave
// raster order.
// The line store is a single-port-write, single-port-read memory of 2*q_max-1 rows.
// Every filtered pixel walks the four q-by-q quadrants through the memory read port,
// one pixel per cycle, then divides the winning sum over a bit-serial divider of
// SUMW bits, the width of a quadrant sum (16 for the default build). An input that
// finishes a window therefore occupies the block through the walk, the evaluation,
// the division and the emits. A new pixel is accepted only while the core is idle,
// but a finished result may still wait in the output register when it is.
// Reset clears the row and column counters and loads q = 3 and a 1024 x 1024 frame;
// the line store is not cleared and needs no clearing pass. When the receiver
// stalls, the result holds in the output register and the core waits before
// loading the next one. The configuration port is APB-like with pready tied high.
`default_nettype none
module kuwahara_filter_gray_core #(
    parameter int MAX_QUADRANT = 16,
    parameter int MAX_DIM      = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input stream. s_tdata: [7:0] pixel.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [kfg_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Output stream. m_tdata: [7:0] out_pixel, [17:8] out_row, [27:18] out_col,
    // [31:28] zero. m_tlast: last_of_run.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [kfg_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [kfg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    import kfg_pkg::*;

    localparam int LINES = 2 * MAX_QUADRANT - 1;
    localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int QW    = $clog2(MAX_QUADRANT + 1);
    localparam int CW    = $clog2(MAX_DIM);
    localparam int DIMW  = $clog2(MAX_DIM + 1);
    localparam int PW    = ((DIMW > DIM_W) ? DIMW : DIM_W) + 1;
    localparam int AW    = $clog2(LINES * MAX_DIM);
    localparam int DEPTH = LINES * MAX_DIM;
    localparam int NMAX  = MAX_QUADRANT * MAX_QUADRANT;
    localparam int NW    = $clog2(NMAX + 1);
    localparam int SUMW  = $clog2(NMAX * 255 + 1);
    localparam int SQW   = $clog2(NMAX * 65025 + 1);
    localparam int SPW   = NW + SQW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EVAL1,
        S_EVAL2,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT_F,
        S_EMIT_B
    } state_t;

    // Configuration registers.
    logic [QS_W-1:0]  qs_reg;
    logic [DIM_W-1:0] wd_reg;
    logic [DIM_W-1:0] ht_reg;

    // Position of the next pixel, and its line store row.
    logic [CW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic [SW-1:0]    slot_reg;

    // Per-item context.
    state_t           state_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    c_reg;
    logic [CW-1:0]    h_reg;
    logic [CW-1:0]    w_reg;
    logic             border_reg;
    logic [QW-1:0]    qm1_reg;
    logic [NW-1:0]    n_reg;
    logic [SW-1:0]    top_a_reg;
    logic [SW-1:0]    top_b_reg;
    logic [CW-1:0]    left_a_reg;
    logic [CW-1:0]    left_b_reg;

    // Quadrant walk.
    logic [1:0]       quad_reg;
    logic [QW-1:0]    i_reg;
    logic [QW-1:0]    j_reg;
    logic [SW-1:0]    rs_reg;
    logic [CW-1:0]    cc_reg;
    logic             p1_v_reg;
    logic             p1_last_reg;
    logic             p2_v_reg;
    logic             p2_last_reg;
    logic [PIX_W-1:0] rdata_reg;
    logic [PIX_W-1:0] pix2_reg;
    logic [2*PIX_W-1:0] sq2_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [SQW-1:0]   ss_reg;
    logic [SPW-1:0]   prod_a_reg;
    logic [SPW-1:0]   prod_b_reg;
    logic [SPW-1:0]   best_reg;
    logic [SUMW-1:0]  best_sum_reg;

    // Output register.
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] o_pix_reg;
    logic [CW-1:0]    o_row_reg;
    logic [CW-1:0]    o_col_reg;
    logic             o_last_reg;

    // Line store.
    logic [PIX_W-1:0] mem [DEPTH];

    logic [QW-1:0]    q_eff;
    logic [PW-1:0]    wd_eff;
    logic [PW-1:0]    ht_eff;
    logic [PW-1:0]    qx;
    logic [PW-1:0]    c0;
    logic [PW-1:0]    r0;
    logic [SW-1:0]    slot0;
    logic [PW-1:0]    c1;
    logic [PW-1:0]    r1;
    logic [SW-1:0]    slot1;
    logic [CW-1:0]    col_next;
    logic [CW-1:0]    row_next;
    logic [SW-1:0]    slot_next;
    logic             interior;
    logic             border;
    logic [SW-1:0]    da;
    logic [SW-1:0]    db;
    logic [SW:0]      top_a_w;
    logic [SW:0]      top_b_w;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             in_xfer;
    logic             out_free;
    logic             cfg_wr;
    logic [SPW-1:0]   spread;
    logic [CW-1:0]    left_cur;
    logic             walk_last;
    logic             div_start;
    logic [SUMW-1:0]  div_quo;
    logic             div_done;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] res;
        if (s == SW'(LINES - 1))
        begin
            res = '0;
        end
        else
        begin
            res = s + 1'b1;
        end
        return res;
    endfunction

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // Out-of-range register values are clamped into the supported range.
    always_comb
    begin
        if (qs_reg == '0)
        begin
            q_eff = QW'(1);
        end
        else if (32'(qs_reg) > MAX_QUADRANT)
        begin
            q_eff = QW'(MAX_QUADRANT);
        end
        else
        begin
            q_eff = QW'(qs_reg);
        end

        if (wd_reg == '0)
        begin
            wd_eff = PW'(1);
        end
        else if (32'(wd_reg) > MAX_DIM)
        begin
            wd_eff = PW'(MAX_DIM);
        end
        else
        begin
            wd_eff = PW'(wd_reg);
        end

        if (ht_reg == '0)
        begin
            ht_eff = PW'(1);
        end
        else if (32'(ht_reg) > MAX_DIM)
        begin
            ht_eff = PW'(MAX_DIM);
        end
        else
        begin
            ht_eff = PW'(ht_reg);
        end
    end

    // Position of the arriving pixel, its classification and the next position.
    always_comb
    begin
        qx = PW'(q_eff);

        c0    = PW'(col_reg);
        r0    = PW'(row_reg);
        slot0 = slot_reg;
        if (PW'(col_reg) >= wd_eff)
        begin
            c0    = '0;
            r0    = PW'(row_reg) + 1'b1;
            slot0 = slot_inc(slot_reg);
        end
        if (r0 >= ht_eff)
        begin
            r0    = '0;
            slot0 = '0;
        end

        interior = (r0 + 1'b1 >= (qx << 1)) && (c0 + 1'b1 >= (qx << 1)) &&
                   (r0 + 1'b1 < ht_eff) && (c0 + 1'b1 < wd_eff);
        border   = (r0 < qx) || (r0 + qx >= ht_eff) ||
                   (c0 < qx) || (c0 + qx >= wd_eff);

        // Window rows relative to the current row, wrapped round the line store.
        da = SW'((qx << 1) - PW'(2));
        db = SW'(qx - PW'(1));
        if (slot0 >= da)
        begin
            top_a_w = {1'b0, slot0} - {1'b0, da};
        end
        else
        begin
            top_a_w = {1'b0, slot0} + (SW + 1)'(LINES) - {1'b0, da};
        end
        if (slot0 >= db)
        begin
            top_b_w = {1'b0, slot0} - {1'b0, db};
        end
        else
        begin
            top_b_w = {1'b0, slot0} + (SW + 1)'(LINES) - {1'b0, db};
        end

        c1        = c0 + 1'b1;
        col_next  = CW'(c1);
        row_next  = CW'(r0);
        slot_next = slot0;
        r1        = r0;
        if (c1 >= wd_eff)
        begin
            col_next  = '0;
            r1        = r0 + 1'b1;
            slot1     = slot_inc(slot0);
            row_next  = CW'(r1);
            slot_next = slot1;
            if (r1 >= ht_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
        end
        else
        begin
            slot1 = slot0;
        end
    end

    assign wr_addr   = AW'(slot0) * AW'(MAX_DIM) + AW'(c0);
    assign rd_addr   = AW'(rs_reg) * AW'(MAX_DIM) + AW'(cc_reg);
    assign left_cur  = quad_reg[0] ? left_b_reg : left_a_reg;
    assign walk_last = (i_reg == qm1_reg) && (j_reg == qm1_reg);
    assign spread    = prod_a_reg - prod_b_reg;
    assign div_start = (state_reg == S_DIV_GO);

    // Line store: one write port for arriving pixels, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mem[wr_addr] <= s_tdata[PIX_W-1:0];
        end
        rdata_reg <= mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qs_reg <= QS_W'(3);
            wd_reg <= DIM_W'(1024);
            ht_reg <= DIM_W'(1024);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_QUADRANT_SIDE: qs_reg <= pwdata[QS_W-1:0];
                REG_IMAGE_WIDTH:   wd_reg <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  ht_reg <= pwdata[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_QUADRANT_SIDE: prdata = 32'(qs_reg);
            REG_IMAGE_WIDTH:   prdata = 32'(wd_reg);
            REG_IMAGE_HEIGHT:  prdata = 32'(ht_reg);
            default:           prdata = '0;
        endcase
    end

    // Sequencer, quadrant walk and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            quad_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            p1_v_reg     <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_v_reg     <= 1'b0;
            p2_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Read pipeline: address issued, data registered, square registered.
            p1_v_reg    <= (state_reg == S_ISSUE);
            p1_last_reg <= (state_reg == S_ISSUE) && walk_last;
            p2_v_reg    <= p1_v_reg;
            p2_last_reg <= p1_last_reg;
            pix2_reg    <= rdata_reg;
            sq2_reg     <= rdata_reg * rdata_reg;
            if (p2_v_reg)
            begin
                sum_reg <= sum_reg + SUMW'(pix2_reg);
                ss_reg  <= ss_reg + SQW'(sq2_reg);
            end

            // The emit states load the output register themselves.
            if (m_tready && state_reg != S_EMIT_F && state_reg != S_EMIT_B)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        col_reg    <= col_next;
                        row_reg    <= row_next;
                        slot_reg   <= slot_next;
                        pix_reg    <= s_tdata[PIX_W-1:0];
                        r_reg      <= CW'(r0);
                        c_reg      <= CW'(c0);
                        h_reg      <= CW'(r0 - qx + 1'b1);
                        w_reg      <= CW'(c0 - qx + 1'b1);
                        border_reg <= border;
                        qm1_reg    <= q_eff - 1'b1;
                        n_reg      <= NW'(q_eff * q_eff);
                        top_a_reg  <= SW'(top_a_w);
                        top_b_reg  <= SW'(top_b_w);
                        left_a_reg <= CW'(c0 - (qx << 1) + PW'(2));
                        left_b_reg <= CW'(c0 - qx + PW'(1));
                        quad_reg   <= '0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        rs_reg     <= SW'(top_a_w);
                        cc_reg     <= CW'(c0 - (qx << 1) + PW'(2));
                        sum_reg    <= '0;
                        ss_reg     <= '0;
                        if (interior)
                        begin
                            state_reg <= S_ISSUE;
                        end
                        else if (border)
                        begin
                            state_reg <= S_EMIT_B;
                        end
                    end
                end

                S_ISSUE:
                begin
                    if (j_reg == qm1_reg)
                    begin
                        j_reg  <= '0;
                        i_reg  <= i_reg + 1'b1;
                        cc_reg <= left_cur;
                        rs_reg <= slot_inc(rs_reg);
                    end
                    else
                    begin
                        j_reg  <= j_reg + 1'b1;
                        cc_reg <= cc_reg + 1'b1;
                    end
                    if (walk_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    if (p2_v_reg && p2_last_reg)
                    begin
                        state_reg <= S_EVAL1;
                    end
                end

                S_EVAL1:
                begin
                    prod_a_reg <= SPW'(n_reg) * SPW'(ss_reg);
                    prod_b_reg <= SPW'(sum_reg) * SPW'(sum_reg);
                    state_reg  <= S_EVAL2;
                end

                S_EVAL2:
                begin
                    // Strictly smaller wins, so ties stay with the earlier quadrant.
                    if (quad_reg == 2'd0 || spread < best_reg)
                    begin
                        best_reg     <= spread;
                        best_sum_reg <= sum_reg;
                    end
                    if (quad_reg == 2'd3)
                    begin
                        state_reg <= S_DIV_GO;
                    end
                    else
                    begin
                        quad_reg  <= quad_reg + 1'b1;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rs_reg    <= quad_reg[1] || quad_reg[0] ? top_b_reg : top_a_reg;
                        cc_reg    <= quad_reg[0] ? left_a_reg : left_b_reg;
                        sum_reg   <= '0;
                        ss_reg    <= '0;
                        state_reg <= S_ISSUE;
                    end
                end

                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EMIT_F;
                    end
                end

                S_EMIT_F:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        o_pix_reg    <= div_quo[PIX_W-1:0];
                        o_row_reg    <= h_reg;
                        o_col_reg    <= w_reg;
                        o_last_reg   <= !border_reg;
                        state_reg    <= border_reg ? S_EMIT_B : S_IDLE;
                    end
                end

                S_EMIT_B:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        o_pix_reg    <= pix_reg;
                        o_row_reg    <= r_reg;
                        o_col_reg    <= c_reg;
                        o_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    kfg_div #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (best_sum_reg),
        .divisor  (n_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {OUT_PAD_W'(0), POS_W'(o_col_reg), POS_W'(o_row_reg), o_pix_reg};

endmodule
`default_nettype wire

### rtl/core/kfg_checker.sv
// Port-level checks for the Kuwahara filter core, bound to the top level.
`default_nettype none
module kfg_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [kfg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire logic                              m_tlast,
    input wire logic                              pready
);

    import kfg_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The padding bits above the column field are always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_TDATA_W-OUT_PAD_W] == '0)
        else $error("tdata padding not zero");

    // A filtered result that is not last is followed at once by the border result.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second result of a run missing");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // An input is only taken while the core is idle, so no input is taken while a run's first result is handed over.
    a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !(s_tvalid && s_tready))
        else $error("input accepted in the middle of a run");

endmodule

bind kuwahara_filter_gray_core kfg_checker u_kfg_checker (.*);
`default_nettype wire
